FILE: rtl/per_path_serial_dispatch_queue_macros.svh
// Assertion helpers for the checker file.
`ifndef PER_PATH_SERIAL_DISPATCH_QUEUE_MACROS_SVH
`define PER_PATH_SERIAL_DISPATCH_QUEUE_MACROS_SVH

// Check post in the same cycle whenever pre holds.
`define PPSDQ_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Check post in the cycle after pre holds.
`define PPSDQ_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/ppsdq_pkg.sv
package ppsdq_pkg;

  localparam int CMD_W       = 2;
  localparam int PATH_W      = 3;
  localparam int TASK_W      = 16;
  localparam int OC_W        = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [CMD_W-1:0] {
    CMD_SUBMIT     = 2'd0,
    CMD_DONE       = 2'd1,
    CMD_RESET_PATH = 2'd2,
    CMD_RESET_ALL  = 2'd3
  } cmd_t;

  typedef enum logic [OC_W-1:0] {
    OC_DISPATCHED  = 3'd0,
    OC_QUEUED      = 3'd1,
    OC_IDLE        = 3'd2,
    OC_DISCARDED   = 3'd3,
    OC_RESET_EMPTY = 3'd4,
    OC_REJECTED    = 3'd5
  } oc_t;

  typedef struct packed {
    logic              last;
    logic [TASK_W-1:0] out_task;
    logic [PATH_W-1:0] out_path;
    oc_t               outcome;
  } res_t;

endpackage

FILE: rtl/ppsdq_out_stage.sv
module ppsdq_out_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  ppsdq_pkg::res_t                    res,
  output logic                               free,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ppsdq_pkg::OUT_TDATA_W-1:0]  m_tdata,   // outcome, out_path, out_task, zero pad
  output logic                               m_tlast
);
  import ppsdq_pkg::*;

  res_t held;

  assign free     = !m_tvalid || m_tready;
  assign m_tdata  = OUT_TDATA_W'({held.out_task, held.out_path, held.outcome});
  assign m_tlast  = held.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

endmodule

FILE: rtl/per_path_serial_dispatch_queue.sv
// Per-path serial dispatch queue. Takes one request at a time and answers each request
// whose path is below PATHS with one or more results on the master stream, tlast on the
// final one. Per-path state (busy, FIFO head, FIFO count) lives in a small metadata RAM,
// the queued tags in a tag RAM of PATHS*QUEUE_DEPTH entries; both have registered reads.
// A submit or a completion with nothing queued goes through accept, metadata read and
// result; a completion that pops a tag adds a tag RAM read. A path reset gives one result
// per discarded tag, or one reset-empty result. A reset of all paths scans the metadata
// once to find the last non-empty FIFO, then walks the paths again up to that one, one
// result per discarded tag. Per-path valid bits clear at reset, so no clearing pass is
// needed. Output stalls hold the sequencer in every state that has a result to emit.
module per_path_serial_dispatch_queue #(
  parameter int PATHS       = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int TAG_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ppsdq_pkg::IN_TDATA_W-1:0]  s_tdata,   // command, path_id, task_tag, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ppsdq_pkg::OUT_TDATA_W-1:0] m_tdata,   // outcome, out_path, out_task, zero pad
  output logic                              m_tlast
);
  import ppsdq_pkg::*;

  localparam int PW = (PATHS > 1) ? $clog2(PATHS) : 1;
  localparam int DW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = (PATHS * QUEUE_DEPTH > 1) ? $clog2(PATHS * QUEUE_DEPTH) : 1;
  localparam int TW = (TAG_BITS < TASK_W) ? TAG_BITS : TASK_W;

  typedef struct packed {
    logic          busy;
    logic [DW-1:0] head;
    logic [CW-1:0] count;
  } meta_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_META  = 6'b000010,
    S_POP   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SCAN  = 6'b010000,
    S_WALK  = 6'b100000
  } state_t;

  function automatic logic [DW-1:0] wrap_add(input logic [DW-1:0] a, input logic [DW:0] b);
    logic [DW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= (DW+2)'(QUEUE_DEPTH)) begin
      s = s - (DW+2)'(QUEUE_DEPTH);
    end
    return s[DW-1:0];
  endfunction

  function automatic logic [AW-1:0] st_addr(input logic [PW-1:0] p, input logic [DW-1:0] s);
    return AW'(p) * AW'(QUEUE_DEPTH) + AW'(s);
  endfunction

  function automatic res_t mk_res(input oc_t oc, input logic [PW-1:0] p,
                                  input logic [TW-1:0] t, input logic l);
    res_t r;
    r.outcome  = oc;
    r.out_path = PATH_W'(p);
    r.out_task = TASK_W'(t);
    r.last     = l;
    return r;
  endfunction

  // Memories
  meta_t          meta_mem [PATHS];
  logic [TW-1:0]  store_mem [PATHS * QUEUE_DEPTH];
  meta_t          meta_rd;
  logic           meta_rd_vld;
  logic [TW-1:0]  store_rd;
  logic [PATHS-1:0] meta_vld;

  // Sequencer registers
  state_t        state, state_next;
  cmd_t          cmd, cmd_next;
  logic [PW-1:0] q, q_next;
  logic [PW-1:0] last_q, last_q_next;
  logic          found, found_next;
  logic [TW-1:0] tag, tag_next;
  logic [DW-1:0] k, k_next;
  logic [DW-1:0] head, head_next;
  logic [CW-1:0] cnt, cnt_next;

  // Memory and output controls
  logic          meta_re, meta_we, vld_clr_one, vld_clr_all;
  logic [PW-1:0] meta_ra;
  meta_t         meta_wd, meta_cur;
  logic          store_re, store_we;
  logic [AW-1:0] store_ra, store_wa;
  logic          res_push, out_free;
  res_t          res;

  cmd_t              cmd_in;
  logic [PATH_W-1:0] path_in;
  logic [TASK_W-1:0] tag_in;
  logic              nonempty, found_n;
  logic [DW:0]       k1;

  assign cmd_in   = cmd_t'(s_tdata[CMD_W-1:0]);
  assign path_in  = s_tdata[CMD_W +: PATH_W];
  assign tag_in   = s_tdata[CMD_W + PATH_W +: TASK_W];
  assign s_tready = (state == S_IDLE);
  assign meta_cur = meta_rd_vld ? meta_rd : '0;
  assign nonempty = (meta_cur.count != '0);
  assign found_n  = found | nonempty;
  assign k1       = {1'b0, k} + (DW+1)'(1);

  always_comb begin
    state_next  = state;
    cmd_next    = cmd;
    q_next      = q;
    last_q_next = last_q;
    found_next  = found;
    tag_next    = tag;
    k_next      = k;
    head_next   = head;
    cnt_next    = cnt;
    meta_re     = 1'b0;
    meta_ra     = q;
    meta_we     = 1'b0;
    meta_wd     = meta_cur;
    vld_clr_one = 1'b0;
    vld_clr_all = 1'b0;
    store_re    = 1'b0;
    store_ra    = st_addr(q, meta_cur.head);
    store_we    = 1'b0;
    store_wa    = st_addr(q, wrap_add(meta_cur.head, (DW+1)'(meta_cur.count)));
    res_push    = 1'b0;
    res         = mk_res(OC_DISPATCHED, q, tag, 1'b1);

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd_next = cmd_in;
          tag_next = TW'(tag_in);
          q_next   = PW'(path_in);
          if (cmd_in == CMD_RESET_ALL) begin
            q_next     = '0;
            found_next = 1'b0;
            meta_re    = 1'b1;
            meta_ra    = '0;
            state_next = S_SCAN;
          end else if (32'(path_in) < PATHS) begin
            meta_re    = 1'b1;
            meta_ra    = PW'(path_in);
            state_next = S_META;
          end
        end
      end

      S_META: begin
        if (out_free) begin
          unique case (cmd)
            CMD_SUBMIT: begin
              res_push   = 1'b1;
              state_next = S_IDLE;
              if (!meta_cur.busy) begin
                meta_we      = 1'b1;
                meta_wd.busy = 1'b1;
                res          = mk_res(OC_DISPATCHED, q, tag, 1'b1);
              end else if (meta_cur.count >= CW'(QUEUE_DEPTH)) begin
                res = mk_res(OC_REJECTED, q, tag, 1'b1);
              end else begin
                store_we      = 1'b1;
                meta_we       = 1'b1;
                meta_wd.count = meta_cur.count + CW'(1);
                res           = mk_res(OC_QUEUED, q, tag, 1'b1);
              end
            end
            CMD_DONE: begin
              meta_we = 1'b1;
              if (nonempty) begin
                store_re      = 1'b1;
                meta_wd.head  = wrap_add(meta_cur.head, (DW+1)'(1));
                meta_wd.count = meta_cur.count - CW'(1);
                meta_wd.busy  = 1'b1;
                state_next    = S_POP;
              end else begin
                meta_wd.busy = 1'b0;
                res          = mk_res(OC_IDLE, q, '0, 1'b1);
                res_push     = 1'b1;
                state_next   = S_IDLE;
              end
            end
            CMD_RESET_PATH: begin
              if (nonempty) begin
                head_next  = meta_cur.head;
                cnt_next   = meta_cur.count;
                k_next     = '0;
                store_re   = 1'b1;
                state_next = S_DRAIN;
              end else begin
                vld_clr_one = 1'b1;
                res         = mk_res(OC_RESET_EMPTY, q, '0, 1'b1);
                res_push    = 1'b1;
                state_next  = S_IDLE;
              end
            end
            CMD_RESET_ALL: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_POP: begin
        if (out_free) begin
          res        = mk_res(OC_DISPATCHED, q, store_rd, 1'b1);
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DRAIN: begin
        if (out_free) begin
          res_push = 1'b1;
          res      = mk_res(OC_DISCARDED, q, store_rd,
                            (k1 == (DW+1)'(cnt)) && (cmd == CMD_RESET_PATH || q == last_q));
          if (k1 != (DW+1)'(cnt)) begin
            k_next   = k1[DW-1:0];
            store_re = 1'b1;
            store_ra = st_addr(q, wrap_add(head, k1));
          end else if (cmd == CMD_RESET_PATH) begin
            vld_clr_one = 1'b1;
            state_next  = S_IDLE;
          end else if (q == last_q) begin
            vld_clr_all = 1'b1;
            state_next  = S_IDLE;
          end else begin
            q_next     = q + PW'(1);
            meta_re    = 1'b1;
            meta_ra    = q + PW'(1);
            state_next = S_WALK;
          end
        end
      end

      S_SCAN: begin
        if (q == PW'(PATHS - 1)) begin
          if (found_n) begin
            found_next = 1'b1;
            if (nonempty) begin
              last_q_next = q;
            end
            q_next     = '0;
            meta_re    = 1'b1;
            meta_ra    = '0;
            state_next = S_WALK;
          end else if (out_free) begin
            res         = mk_res(OC_RESET_EMPTY, '0, '0, 1'b1);
            res_push    = 1'b1;
            vld_clr_all = 1'b1;
            state_next  = S_IDLE;
          end
        end else begin
          found_next = found_n;
          if (nonempty) begin
            last_q_next = q;
          end
          q_next  = q + PW'(1);
          meta_re = 1'b1;
          meta_ra = q + PW'(1);
        end
      end

      S_WALK: begin
        if (nonempty) begin
          head_next  = meta_cur.head;
          cnt_next   = meta_cur.count;
          k_next     = '0;
          store_re   = 1'b1;
          state_next = S_DRAIN;
        end else begin
          q_next  = q + PW'(1);
          meta_re = 1'b1;
          meta_ra = q + PW'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      meta_vld    <= '0;
      meta_rd_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (meta_re) begin
        meta_rd_vld <= meta_vld[meta_ra];
      end
      if (vld_clr_all) begin
        meta_vld <= '0;
      end else if (vld_clr_one) begin
        meta_vld[q] <= 1'b0;
      end else if (meta_we) begin
        meta_vld[q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd    <= cmd_next;
    q      <= q_next;
    last_q <= last_q_next;
    found  <= found_next;
    tag    <= tag_next;
    k      <= k_next;
    head   <= head_next;
    cnt    <= cnt_next;
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[q] <= meta_wd;
    end
    if (meta_re) begin
      meta_rd <= meta_mem[meta_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= tag;
    end
    if (store_re) begin
      store_rd <= store_mem[store_ra];
    end
  end

  ppsdq_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: rtl/ppsdq_checker.sv
`include "per_path_serial_dispatch_queue_macros.svh"

module ppsdq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [ppsdq_pkg::IN_TDATA_W-1:0]  s_tdata,   // command, path_id, task_tag, zero pad
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ppsdq_pkg::OUT_TDATA_W-1:0] m_tdata,   // outcome, out_path, out_task, zero pad
  input logic                              m_tlast
);
  import ppsdq_pkg::*;

  logic [OC_W-1:0]   oc;
  logic [TASK_W-1:0] out_task;
  logic              oc_single, oc_no_tag, stalled, all_in;

  assign oc        = m_tdata[OC_W-1:0];
  assign out_task  = m_tdata[OC_W + PATH_W +: TASK_W];
  assign oc_single = (oc == OC_QUEUED) || (oc == OC_IDLE) ||
                     (oc == OC_RESET_EMPTY) || (oc == OC_REJECTED);
  assign oc_no_tag = (oc == OC_IDLE) || (oc == OC_RESET_EMPTY);
  assign stalled   = m_tvalid && !m_tready;
  assign all_in    = s_tvalid && s_tready && (s_tdata[CMD_W-1:0] == CMD_RESET_ALL);

  `PPSDQ_ASSERT_NEXT(a_hold_valid, stalled, m_tvalid, "result dropped while stalled")
  `PPSDQ_ASSERT_NEXT(a_hold_data, stalled, $stable(m_tdata) && $stable(m_tlast), "result changed")
  `PPSDQ_ASSERT_NEXT(a_reset_all_busy, all_in, !s_tready, "request taken during reset all")
  `PPSDQ_ASSERT_NOW(a_single_last, m_tvalid && oc_single, m_tlast, "single result without tlast")
  `PPSDQ_ASSERT_NOW(a_no_tag, m_tvalid && oc_no_tag, out_task == '0, "tag on an untagged outcome")

endmodule

bind per_path_serial_dispatch_queue ppsdq_checker u_ppsdq_checker (.*);
